// ===== rtl/fbrf_pkg.sv =====
package fbrf_pkg;

  // rows held in one page byte
  localparam int unsigned PageRows = 8;

  // field widths fixed by the item format
  localparam int unsigned KindW   = 2;
  localparam int unsigned XW      = 9;
  localparam int unsigned YW      = 7;
  localparam int unsigned SpanW   = 6;
  localparam int unsigned PageSelW = 2;
  localparam int unsigned ColSelW = 7;

  typedef enum logic [KindW-1:0] {
    KIND_FILL  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FILL
  } state_e;

  // read response control, registered in the cycle after a read is taken
  typedef struct packed {
    logic valid;
    logic zero;
  } rsp_t;

endpackage

// ===== rtl/framebuffer_rect_fill_page_pack_core.sv =====
// channel    signals                                       transfer when
// ---------  --------------------------------------------  ----------------------
// command    start, busy, kind_i, x_i, y_i, width_i,       start && !busy
//            height_i, page_i, column_i
// result     strobe_o, pixel_byte_o                        strobe_o (no stall)
//
// read: the byte shows with strobe_o on the cycle after the
//   transfer, and busy stays low so a command may follow at once
// fill: one store byte per cycle over the clipped pages x columns, each read and
//   written back with the mask ORed in; busy stays high until the last write-back
// clear: one byte per cycle over all pages*SCREEN_COLS store entries;
//   the store's single write port, one byte per cycle, sets fill and clear
// reset: runs the same clearing sweep, busy high throughout
// the result side cannot stall, each result is shown for one cycle only
module framebuffer_rect_fill_page_pack_core #(
  parameter int unsigned SCREEN_ROWS = 32,
  parameter int unsigned SCREEN_COLS = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [fbrf_pkg::KindW-1:0]          kind_i,
  input  logic signed [fbrf_pkg::XW-1:0]      x_i,
  input  logic signed [fbrf_pkg::YW-1:0]      y_i,
  input  logic [fbrf_pkg::SpanW-1:0]          width_i,
  input  logic [fbrf_pkg::SpanW-1:0]          height_i,
  input  logic [fbrf_pkg::PageSelW-1:0]       page_i,
  input  logic [fbrf_pkg::ColSelW-1:0]        column_i,
  output logic                                strobe_o,
  output logic [fbrf_pkg::PageRows-1:0]       pixel_byte_o
);

  import fbrf_pkg::*;

  // page-packed store: entry page*SCREEN_COLS + column, bit r is row 8*page+r
  localparam int unsigned PageCount = (SCREEN_ROWS + 7) / 8;
  localparam int unsigned Depth     = PageCount * SCREEN_COLS;
  localparam int unsigned AddrW     = $clog2(Depth);

  logic                 rd_en;
  logic [AddrW-1:0]     rd_addr;
  logic [PageRows-1:0]  rd_data;
  logic                 wr_en;
  logic [AddrW-1:0]     wr_addr;
  logic [PageRows-1:0]  wr_data;
  rsp_t                 rsp;

  // sequencer: clipping, fill walk with read-modify-write, clear sweep
  fbrf_ctrl #(
    .SCREEN_ROWS (SCREEN_ROWS),
    .SCREEN_COLS (SCREEN_COLS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .busy_o    (busy),
    .kind_i    (kind_i),
    .x_i       (x_i),
    .y_i       (y_i),
    .width_i   (width_i),
    .height_i  (height_i),
    .page_i    (page_i),
    .column_i  (column_i),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rsp_o     (rsp)
  );

  fbrf_ram #(
    .Width (PageRows),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // a read off the screen answers zero instead of store data
  assign strobe_o     = rsp.valid;
  assign pixel_byte_o = rsp.zero ? '0 : rd_data;

endmodule

// ===== rtl/fbrf_ram.sv =====
module fbrf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fbrf_ctrl.sv =====
module fbrf_ctrl #(
  parameter int unsigned SCREEN_ROWS = 32,
  parameter int unsigned SCREEN_COLS = 128,
  localparam int unsigned PageCount = (SCREEN_ROWS + 7) / 8,
  localparam int unsigned Depth = PageCount * SCREEN_COLS,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [fbrf_pkg::KindW-1:0]          kind_i,
  input  logic signed [fbrf_pkg::XW-1:0]      x_i,
  input  logic signed [fbrf_pkg::YW-1:0]      y_i,
  input  logic [fbrf_pkg::SpanW-1:0]          width_i,
  input  logic [fbrf_pkg::SpanW-1:0]          height_i,
  input  logic [fbrf_pkg::PageSelW-1:0]       page_i,
  input  logic [fbrf_pkg::ColSelW-1:0]        column_i,
  output logic                                rd_en_o,
  output logic [AddrW-1:0]                    rd_addr_o,
  input  logic [fbrf_pkg::PageRows-1:0]       rd_data_i,
  output logic                                wr_en_o,
  output logic [AddrW-1:0]                    wr_addr_o,
  output logic [fbrf_pkg::PageRows-1:0]       wr_data_o,
  output fbrf_pkg::rsp_t                      rsp_o
);

  import fbrf_pkg::*;

  localparam int unsigned PageW = (PageCount > 1) ? $clog2(PageCount) : 1;
  localparam int unsigned RowW  = PageW + 3;
  localparam int unsigned ColW  = $clog2(SCREEN_COLS);
  localparam logic signed [XW:0] ColMax = (XW + 1)'(SCREEN_COLS - 1);
  localparam logic signed [YW:0] RowMax = (YW + 1)'(SCREEN_ROWS - 1);

  state_e               state_q, state_d;
  logic [AddrW-1:0]     clr_q, clr_d;
  logic                 wr_pend_q, wr_pend_d;
  logic [AddrW-1:0]     wr_addr_q, wr_addr_d;
  logic [PageRows-1:0]  mask_q, mask_d;
  rsp_t                 rsp_q, rsp_d;
  logic [ColW-1:0]      col_q, col_d;
  logic [ColW-1:0]      col_lo_q, col_lo_d;
  logic [ColW-1:0]      col_hi_q, col_hi_d;
  logic [RowW-1:0]      row_lo_q, row_lo_d;
  logic [RowW-1:0]      row_hi_q, row_hi_d;
  logic [PageW-1:0]     page_q, page_d;
  logic [PageW-1:0]     page_end_q, page_end_d;
  logic [AddrW-1:0]     base_q, base_d;

  logic                 accept;
  logic                 accept_read;
  logic signed [XW:0]   x_lo_s, x_hi_s;
  logic signed [YW:0]   y_lo_s, y_hi_s;
  logic                 fill_off;
  logic [ColW-1:0]      col_lo_c, col_hi_c;
  logic [RowW-1:0]      row_lo_c, row_hi_c;
  logic [AddrW-1:0]     fill_addr;
  logic [AddrW-1:0]     read_addr;
  logic                 read_oob;
  logic [PageRows-1:0]  mask_cur;
  logic [RowW-1:0]      row_tap [PageRows];

  assign busy_o      = (state_q != ST_IDLE) || wr_pend_q;
  assign accept      = start_i && !busy_o;
  assign accept_read = accept && (kind_i == KIND_READ);

  // rectangle clipping, inclusive bounds
  assign x_lo_s   = {x_i[XW-1], x_i};
  assign x_hi_s   = x_lo_s + $signed({{(XW + 1 - SpanW){1'b0}}, width_i});
  assign y_lo_s   = {y_i[YW-1], y_i};
  assign y_hi_s   = y_lo_s + $signed({{(YW + 1 - SpanW){1'b0}}, height_i});
  assign fill_off = (x_hi_s < 0) || (x_lo_s > ColMax) || (y_hi_s < 0) || (y_lo_s > RowMax);
  assign col_lo_c = x_lo_s[XW] ? '0 : x_lo_s[ColW-1:0];
  assign col_hi_c = (x_hi_s > ColMax) ? ColMax[ColW-1:0] : x_hi_s[ColW-1:0];
  assign row_lo_c = y_lo_s[YW] ? '0 : y_lo_s[RowW-1:0];
  assign row_hi_c = (y_hi_s > RowMax) ? RowMax[RowW-1:0] : y_hi_s[RowW-1:0];

  assign fill_addr = base_q + AddrW'(col_q);
  assign read_addr = AddrW'(32'(page_i) * SCREEN_COLS + 32'(column_i));
  assign read_oob  = (32'(page_i) >= PageCount) || (32'(column_i) >= SCREEN_COLS);

  // rows of the current page that fall inside the rectangle
  always_comb begin
    for (int r = 0; r < PageRows; r++) begin
      row_tap[r]  = {page_q, 3'(r)};
      mask_cur[r] = (row_tap[r] >= row_lo_q) && (row_tap[r] <= row_hi_q);
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    wr_pend_d  = 1'b0;
    wr_addr_d  = wr_addr_q;
    mask_d     = mask_q;
    rsp_d      = '0;
    col_d      = col_q;
    col_lo_d   = col_lo_q;
    col_hi_d   = col_hi_q;
    row_lo_d   = row_lo_q;
    row_hi_d   = row_hi_q;
    page_d     = page_q;
    page_end_d = page_end_q;
    base_d     = base_q;
    rd_en_o    = 1'b0;
    rd_addr_o  = fill_addr;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_e'(kind_i))
            KIND_FILL: begin
              if (!fill_off) begin
                col_lo_d   = col_lo_c;
                col_hi_d   = col_hi_c;
                row_lo_d   = row_lo_c;
                row_hi_d   = row_hi_c;
                col_d      = col_lo_c;
                page_d     = row_lo_c[RowW-1:3];
                page_end_d = row_hi_c[RowW-1:3];
                base_d     = AddrW'(32'(row_lo_c[RowW-1:3]) * SCREEN_COLS);
                state_d    = ST_FILL;
              end
            end
            KIND_CLEAR: begin
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
            KIND_READ: begin
              rd_en_o    = 1'b1;
              rd_addr_o  = read_addr;
              rsp_d.valid = 1'b1;
              rsp_d.zero  = read_oob;
            end
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_FILL: begin
        // read now, or the mask in and write back next cycle
        rd_en_o   = 1'b1;
        wr_pend_d = 1'b1;
        wr_addr_d = fill_addr;
        mask_d    = mask_cur;
        if (col_q == col_hi_q) begin
          if (page_q == page_end_q) begin
            state_d = ST_IDLE;
          end else begin
            page_d = page_q + 1'b1;
            base_d = base_q + AddrW'(SCREEN_COLS);
            col_d  = col_lo_q;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign wr_en_o   = (state_q == ST_CLEAR) || wr_pend_q;
  assign wr_addr_o = (state_q == ST_CLEAR) ? clr_q : wr_addr_q;
  assign wr_data_o = (state_q == ST_CLEAR) ? '0 : (rd_data_i | mask_q);
  assign rsp_o     = rsp_q;

  // reset starts a clearing sweep over the whole store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      wr_pend_q <= 1'b0;
      rsp_q     <= '0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      wr_pend_q <= wr_pend_d;
      rsp_q     <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q  <= wr_addr_d;
    mask_q     <= mask_d;
    col_q      <= col_d;
    col_lo_q   <= col_lo_d;
    col_hi_q   <= col_hi_d;
    row_lo_q   <= row_lo_d;
    row_hi_q   <= row_hi_d;
    page_q     <= page_d;
    page_end_q <= page_end_d;
    base_q     <= base_d;
  end

  a_clear_no_writeback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !wr_pend_q)
    else $error("clear sweep overlaps a fill write-back");

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_pend_q && rd_en_o) |-> (rd_addr_o != wr_addr_q))
    else $error("read of an entry whose write-back is in flight");

  a_rsp_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_q.valid |-> $past(accept_read))
    else $error("response without a read transfer");

  a_fill_col_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> ((col_q >= col_lo_q) && (col_q <= col_hi_q)))
    else $error("fill column left the clipped window");

endmodule

// ===== tb/tb.sv =====
module tb;
  import fbrf_pkg::*;

  // screen geometry as built, and the page-packed store shape derived from it
  localparam int unsigned ScreenRows = 32;
  localparam int unsigned ScreenCols = 128;
  localparam int unsigned PageCount  = (ScreenRows + PageRows - 1) / PageRows;

  // kind code the block must ignore
  localparam logic [KindW-1:0] KIND_UNUSED = 2'd3;

  localparam int RandomItems = 1000;
  localparam int CycleLimit  = 2_000_000;
  localparam int DirCount    = 25;

  // one command, with an optional typed-in byte for reads
  typedef struct {
    logic [KindW-1:0]           kind;
    logic signed [XW-1:0]       x;
    logic signed [YW-1:0]       y;
    logic [SpanW-1:0]           width;
    logic [SpanW-1:0]           height;
    logic [PageSelW-1:0]        pg;
    logic [ColSelW-1:0]         col;
    bit                         known;
    logic [PageRows-1:0]        want;
  } fb_cmd_t;

  // a byte still owed by the block, with where it was read from
  typedef struct {
    logic [PageRows-1:0]        data;
    logic [PageSelW-1:0]        pg;
    logic [ColSelW-1:0]         col;
  } owed_byte_t;

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  start    = 1'b0;
  logic                  busy;
  logic [KindW-1:0]      kind_i   = '0;
  logic signed [XW-1:0]  x_i      = '0;
  logic signed [YW-1:0]  y_i      = '0;
  logic [SpanW-1:0]      width_i  = '0;
  logic [SpanW-1:0]      height_i = '0;
  logic [PageSelW-1:0]   page_i   = '0;
  logic [ColSelW-1:0]    column_i = '0;
  logic                  strobe_o;
  logic [PageRows-1:0]   pixel_byte_o;

  // our own copy of the screen, page-packed like the block's store
  logic [PageRows-1:0] screen [PageCount][ScreenCols];
  owed_byte_t          owed_bytes [$];
  int                  mismatches = 0;
  int                  cycles     = 0;
  fb_cmd_t             dir_rows [DirCount];

  always #4 clk_i = ~clk_i;

  framebuffer_rect_fill_page_pack_core #(
    .SCREEN_ROWS (ScreenRows),
    .SCREEN_COLS (ScreenCols)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .kind_i       (kind_i),
    .x_i          (x_i),
    .y_i          (y_i),
    .width_i      (width_i),
    .height_i     (height_i),
    .page_i       (page_i),
    .column_i     (column_i),
    .strobe_o     (strobe_o),
    .pixel_byte_o (pixel_byte_o)
  );

  task automatic note_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  // set every on-screen pixel of the inclusive rectangle
  function automatic void shade_rect(int x0, int y0, int w, int h);
    int x1;
    int y1;
    x1 = x0 + w;
    y1 = y0 + h;
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > int'(ScreenCols) - 1) x1 = int'(ScreenCols) - 1;
    if (y1 > int'(ScreenRows) - 1) y1 = int'(ScreenRows) - 1;
    for (int row_n = y0; row_n <= y1; row_n++) begin
      for (int col_n = x0; col_n <= x1; col_n++) begin
        screen[row_n / PageRows][col_n][row_n % PageRows] = 1'b1;
      end
    end
  endfunction

  function automatic void blank_screen();
    foreach (screen[p, c]) screen[p][c] = '0;
  endfunction

  // a page or column past the screen reads as zero
  function automatic logic [PageRows-1:0] page_byte_at(int unsigned pg, int unsigned col);
    if (pg < PageCount && col < ScreenCols) return screen[pg][col];
    return '0;
  endfunction

  // update the prediction for a command at the edge it transfers
  function automatic void take_cmd(input fb_cmd_t c);
    owed_byte_t ob;
    case (c.kind)
      KIND_FILL: begin
        shade_rect(int'(c.x), int'(c.y), int'(c.width), int'(c.height));
      end
      KIND_CLEAR: begin
        blank_screen();
      end
      KIND_READ: begin
        ob.pg   = c.pg;
        ob.col  = c.col;
        ob.data = c.known ? c.want : page_byte_at(c.pg, c.col);
        owed_bytes.push_back(ob);
      end
      default: begin
        // unused kind: no result, no state change
      end
    endcase
  endfunction

  // drive one command and hold it until the block takes it
  task automatic issue(input fb_cmd_t c, input bit hurry);
    int gap;
    gap = hurry ? 0 : $urandom_range(0, 6);
    // start drops only when there is a gap, so it never toggles within one step
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start    <= 1'b1;
    kind_i   <= c.kind;
    x_i      <= c.x;
    y_i      <= c.y;
    width_i  <= c.width;
    height_i <= c.height;
    page_i   <= c.pg;
    column_i <= c.col;
    // transfer happens on the first edge that sees start high and busy low
    do @(posedge clk_i); while (busy);
    take_cmd(c);
  endtask

  // random command: mostly reads and on-screen-ish fills, some full-range noise
  function automatic fb_cmd_t random_cmd();
    fb_cmd_t c;
    int      pick;
    pick     = $urandom_range(0, 99);
    c.x      = XW'($urandom);
    c.y      = YW'($urandom);
    c.width  = SpanW'($urandom);
    c.height = SpanW'($urandom);
    c.pg     = PageSelW'($urandom);
    c.col    = ColSelW'($urandom);
    c.known  = 1'b0;
    c.want   = '0;
    if (pick < 50) begin
      c.kind = KIND_READ;
    end else if (pick < 94) begin
      c.kind = KIND_FILL;
      // most fills land near the screen and stay small so reads see a mix
      if ($urandom_range(0, 4) != 0) begin
        c.x      = XW'(int'($urandom_range(0, 159)) - 16);
        c.y      = YW'(int'($urandom_range(0, 47)) - 8);
        c.width  = SpanW'($urandom_range(0, 31));
        c.height = SpanW'($urandom_range(0, 15));
      end
    end else if (pick < 97) begin
      c.kind = KIND_CLEAR;
    end else begin
      c.kind = KIND_UNUSED;
    end
    return c;
  endfunction

  // result side: every strobe pops the oldest owed byte
  always @(posedge clk_i) begin : watch_bytes
    owed_byte_t ob;
    if (rst_ni && strobe_o) begin
      if (owed_bytes.size() == 0) begin
        note_mismatch($sformatf("byte %02h with no read pending", pixel_byte_o));
      end else begin
        ob = owed_bytes.pop_front();
        if (pixel_byte_o !== ob.data) begin
          note_mismatch($sformatf("page %0d column %0d: got %02h, want %02h",
                                  ob.pg, ob.col, pixel_byte_o, ob.data));
        end
      end
    end
  end

  // run limit, far above the slowest legal run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    fb_cmd_t c;
    int      counted;
    bit      hurry;

    // kind, x, y, width, height, page, column, known, byte
    dir_rows = '{
      // blank after the reset sweep, both corners
      '{KIND_READ,    0,    0,  0,  0, 0,   0, 1'b1, 8'h00},
      '{KIND_READ,    0,    0,  0,  0, 3, 127, 1'b1, 8'h00},
      // wholly off screen on each side
      '{KIND_FILL, -256,  -64, 63, 63, 0,   0, 1'b0, 8'h00},
      '{KIND_FILL,  255,   63, 63, 63, 0,   0, 1'b0, 8'h00},
      '{KIND_FILL,  128,    0,  0,  0, 0,   0, 1'b0, 8'h00},
      '{KIND_FILL,    0,   32, 63, 63, 0,   0, 1'b0, 8'h00},
      '{KIND_READ,    0,    0,  0,  0, 3,   0, 1'b1, 8'h00},
      // unused kind with every field at its top, must leave the store alone
      '{KIND_UNUSED, -1,   -1, 63, 63, 3, 127, 1'b0, 8'h00},
      '{KIND_READ,    0,    0,  0,  0, 0,   5, 1'b1, 8'h00},
      // single pixel at the origin
      '{KIND_FILL,    0,    0,  0,  0, 0,   0, 1'b0, 8'h00},
      '{KIND_READ,    0,    0,  0,  0, 0,   0, 1'b0, 8'h00},
      // partly off the bottom-right corner
      '{KIND_FILL,  120,   28, 63, 63, 0,   0, 1'b0, 8'h00},
      '{KIND_READ,    0,    0,  0,  0, 3, 127, 1'b0, 8'h00},
      // partly off the top-left corner
      '{KIND_FILL,   -5,   -5, 10, 10, 0,   0, 1'b0, 8'h00},
      '{KIND_READ,    0,    0,  0,  0, 0,   3, 1'b0, 8'h00},
      // two widest fills cover the whole screen
      '{KIND_FILL,    0,    0, 63, 63, 0,   0, 1'b0, 8'h00},
      '{KIND_FILL,   64,    0, 63, 63, 0,   0, 1'b0, 8'h00},
      '{KIND_READ,    0,    0,  0,  0, 2, 100, 1'b1, 8'hff},
      '{KIND_READ,    0,    0,  0,  0, 0, 127, 1'b1, 8'hff},
      // clear wipes it again
      '{KIND_CLEAR,   0,    0,  0,  0, 0,   0, 1'b0, 8'h00},
      '{KIND_READ,    0,    0,  0,  0, 1,  64, 1'b1, 8'h00},
      // tall thin bar crossing a page boundary
      '{KIND_FILL,    7,    9,  1, 14, 0,   0, 1'b0, 8'h00},
      '{KIND_READ,    0,    0,  0,  0, 1,   8, 1'b0, 8'h00},
      '{KIND_READ,    0,    0,  0,  0, 2,   7, 1'b0, 8'h00},
      '{KIND_CLEAR,   0,    0,  0,  0, 0,   0, 1'b0, 8'h00}
    };

    blank_screen();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table, gaps still random
    for (int i = 0; i < DirCount; i++) begin
      issue(dir_rows[i], 1'b0);
    end

    // random part; ignored kinds are not counted
    counted = 0;
    hurry   = 1'b0;
    while (counted < RandomItems) begin
      // back-to-back stretches now and then
      if (counted % 64 == 0) hurry = ($urandom_range(0, 3) == 0);
      c = random_cmd();
      issue(c, hurry);
      if (c.kind != KIND_UNUSED) counted++;
    end
    start <= 1'b0;

    // drain owed bytes, then watch past a full clear sweep for stray strobes
    while (owed_bytes.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fbrf_pkg.sv
rtl/fbrf_ram.sv
rtl/fbrf_ctrl.sv
rtl/framebuffer_rect_fill_page_pack_core.sv
tb/tb.sv
